// ===== design/atpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// atpsc_pkg
// shared constants, codes and request types of the two-point sensor calibrator
// ----------------------------------------------------------------------------
package atpsc_pkg;

    localparam int NUM_SAMPLES = 10;
    localparam int ADC_BITS    = 10;
    localparam int TGT_W       = 8;
    localparam int FRAC_W      = 16;
    localparam int ICPT_FRAC_W = 8;
    localparam int SLOPE_W     = 26;
    localparam int ICPT_W      = 28;

    localparam int SUM_W  = $clog2(NUM_SAMPLES * (2 ** ADC_BITS - 1) + 1);
    localparam int CNT_W  = $clog2(NUM_SAMPLES + 1);
    // dividend holds |target delta| scaled by 2^16
    localparam int DIV_W  = TGT_W + FRAC_W;
    localparam int DVSR_W = ADC_BITS;
    localparam int DCNT_W = $clog2(DIV_W + 1);
    localparam int MAC_A_W = SLOPE_W + 1;
    localparam int MAC_W   = MAC_A_W + ADC_BITS + 1;

    // run average as sum * ceil(2^shift / NUM_SAMPLES) >> shift, exact over SUM_W bits
    localparam int AVG_SHIFT  = SUM_W + $clog2(NUM_SAMPLES);
    localparam int REC_W      = SUM_W + 1;
    localparam int AVG_PROD_W = SUM_W + REC_W;
    localparam logic [REC_W-1:0] AVG_RECIP =
        REC_W'((2 ** AVG_SHIFT + NUM_SAMPLES - 1) / NUM_SAMPLES);

    typedef enum logic [1:0] {
        FUNC_MEASURE = 2'd0,
        FUNC_LOW     = 2'd1,
        FUNC_HIGH    = 2'd2,
        FUNC_CAL     = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        KIND_VALUE = 3'd0,
        KIND_LOW   = 3'd1,
        KIND_HIGH  = 3'd2,
        KIND_CAL   = 3'd3,
        KIND_FAIL  = 3'd4
    } t_kind;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                      start;
        logic signed [MAC_A_W-1:0] a;
        logic [ADC_BITS-1:0]       b;
        logic signed [MAC_W-1:0]   c;
    } t_mac_req;

endpackage

// ===== design/atpsc_div.sv =====
// ----------------------------------------------------------------------------
// atpsc_div
// unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module atpsc_div
    import atpsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_div_req         i_req,
    output logic             o_done,
    output logic [DIV_W-1:0] o_quotient
);

    logic              r_busy;
    logic              r_done;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVSR_W-1:0] r_rem;
    logic [DIV_W-1:0]  r_quo;
    logic [DVSR_W-1:0] r_dvsr;

    logic [DVSR_W:0]   w_shift;
    logic [DVSR_W:0]   w_diff;

    assign w_shift = {r_rem, r_quo[DIV_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_quo  <= i_req.dividend;
                r_dvsr <= i_req.divisor;
            end else if (r_busy) begin
                // remainder stays below the divisor, so it fits the divisor width
                if (!w_diff[DVSR_W]) begin
                    r_rem <= w_diff[DVSR_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                end else begin
                    r_rem <= w_shift[DVSR_W-1:0];
                    r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                end
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DCNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a division in flight");

endmodule

// ===== design/atpsc_mac.sv =====
// ----------------------------------------------------------------------------
// atpsc_mac
// registered multiply-add: a * b + c, shared by measure and calibrate
// ----------------------------------------------------------------------------
module atpsc_mac
    import atpsc_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_mac_req                i_req,
    output logic                    o_done,
    output logic signed [MAC_W-1:0] o_result
);

    logic                    r_done;
    logic signed [MAC_W-1:0] r_acc;
    logic signed [MAC_W-1:0] w_prod;
    logic signed [MAC_W-1:0] w_sum;

    assign w_prod = i_req.a * $signed({1'b0, i_req.b});
    assign w_sum  = w_prod + i_req.c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_req.start;
        end
        if (i_req.start) begin
            r_acc <= w_sum;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

endmodule

// ===== design/averaged_two_point_sensor_calibrator_unit.sv =====
// ----------------------------------------------------------------------------
// averaged_two_point_sensor_calibrator_unit
// averages adc runs and maps them through a two-point linear calibration
// ----------------------------------------------------------------------------
// input channel: i_valid / o_stall carry func, sample and target. samples of
// func 0..2 accumulate into a run of NUM_SAMPLES items; a change of func
// restarts the run. an item that does not close a run is taken without a
// stall and gives no result. an item that closes a run, or a calibrate item,
// holds o_stall high until its result is in the output register; the states
// that it passes through before the next item can be taken:
//   measure run closed      S_AVG, S_MEAS (multiply-add), S_FINISH
//   low/high point closed   S_AVG, S_FINISH
//   calibrate               S_CAL_DIV, S_CAL_MAC, S_FINISH; equal points S_FINISH
// the run average is a reciprocal multiply; calibrate is set by the
// restoring divider (one quotient bit per cycle over DIV_W bits) plus one
// pass of the shared multiply-add. a stalled output register holds S_FINISH.
// output channel: o_valid / i_stall carry kind and value from an output
// register; while it is stalled the block keeps taking items, and a finished
// result waits in the sequencer until the register frees up.
// configuration: out_min at 0x0, out_max at 0x4, written by the user only
// while idle; the block does not enforce this. reset (synchronous, active low)
// empties the run, clears both points, sets gain 1, offset 0, limits 0 and 100.
// ----------------------------------------------------------------------------
module averaged_two_point_sensor_calibrator_unit
    import atpsc_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    // input items
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_func,
    input  logic [ADC_BITS-1:0] i_sample,
    input  logic [TGT_W-1:0]    i_target,
    // result items
    output logic                o_valid,
    input  logic                i_stall,
    output logic [2:0]          o_kind,
    output logic [7:0]          o_value
);

    localparam logic REG_OUT_MIN = 1'b0;
    localparam logic REG_OUT_MAX = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_AVG,
        S_MEAS,
        S_CAL_DIV,
        S_CAL_MAC,
        S_FINISH
    } t_state;

    t_state r_state;

    logic [7:0]                r_out_min;
    logic [7:0]                r_out_max;
    logic [SUM_W-1:0]          r_sum;
    logic [CNT_W-1:0]          r_count;
    logic [SUM_W-1:0]          r_close_sum;
    t_func                     r_run_mode;
    logic [ADC_BITS-1:0]       r_low_meas;
    logic [ADC_BITS-1:0]       r_high_meas;
    logic [TGT_W-1:0]          r_low_ref;
    logic [TGT_W-1:0]          r_high_ref;
    logic signed [SLOPE_W-1:0] r_slope;
    logic signed [ICPT_W-1:0]  r_icpt;
    logic signed [SLOPE_W-1:0] r_gain;
    logic                      r_neg;
    t_func                     r_func;
    logic [TGT_W-1:0]          r_target;
    t_kind                     r_res_kind;
    logic [7:0]                r_res_value;
    logic                      r_out_valid;
    t_kind                     r_out_kind;
    logic [7:0]                r_out_value;
    t_div_req                  r_div;
    t_mac_req                  r_mac;

    logic                      w_div_done;
    logic [DIV_W-1:0]          w_quo;
    logic                      w_mac_done;
    logic signed [MAC_W-1:0]   w_mac_res;

    logic                      w_accept;
    logic                      w_cfg_wr;
    logic                      w_restart;
    logic                      w_div_start;
    logic                      w_mac_start;
    logic [SUM_W-1:0]          n_sum;
    logic [CNT_W-1:0]          n_count;
    logic [ADC_BITS:0]         w_dm;
    logic [TGT_W:0]            w_dt;
    logic [ADC_BITS-1:0]       w_dm_mag;
    logic [TGT_W-1:0]          w_dt_mag;
    logic [AVG_PROD_W-1:0]     w_avg_prod;
    logic [ADC_BITS-1:0]       w_avg;
    logic signed [SLOPE_W-1:0] w_gain;
    logic signed [MAC_W-1:0]   w_hi;
    logic signed [MAC_W-1:0]   w_lo;
    logic signed [MAC_W-1:0]   w_t_hi;
    logic signed [MAC_W-1:0]   w_t;
    logic                      w_out_free;

    atpsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (r_div),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    atpsc_mac u_mac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (r_mac),
        .o_done   (w_mac_done),
        .o_result (w_mac_res)
    );

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_OUT_MAX) ? {24'd0, r_out_max} : {24'd0, r_out_min};

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    // run accumulation
    assign w_restart = (t_func'(i_func) != r_run_mode);
    assign n_sum     = (w_restart ? SUM_W'(0) : r_sum) + SUM_W'(i_sample);
    assign n_count   = (w_restart ? CNT_W'(0) : r_count) + 1'b1;

    // calibration deltas as sign and magnitude
    assign w_dm     = {1'b0, r_high_meas} - {1'b0, r_low_meas};
    assign w_dt     = {1'b0, r_high_ref} - {1'b0, r_low_ref};
    assign w_dm_mag = w_dm[ADC_BITS] ? ADC_BITS'(-w_dm) : w_dm[ADC_BITS-1:0];
    assign w_dt_mag = w_dt[TGT_W] ? TGT_W'(-w_dt) : w_dt[TGT_W-1:0];

    assign w_avg_prod = AVG_PROD_W'(r_close_sum) * AVG_PROD_W'(AVG_RECIP);
    assign w_avg      = w_avg_prod[AVG_SHIFT +: ADC_BITS];
    // quotient truncates toward zero: negate the magnitude quotient
    assign w_gain = r_neg ? -$signed(SLOPE_W'(w_quo)) : $signed(SLOPE_W'(w_quo));

    assign w_div_start = w_accept && (t_func'(i_func) == FUNC_CAL) && (w_dm != '0);
    assign w_mac_start = ((r_state == S_AVG) && (r_func == FUNC_MEASURE)) ||
                         ((r_state == S_CAL_DIV) && w_div_done);

    // clamp: upper limit first, lower limit last
    assign w_hi   = $signed({{(MAC_W - 8 - FRAC_W){1'b0}}, r_out_max, {FRAC_W{1'b0}}});
    assign w_lo   = $signed({{(MAC_W - 8 - FRAC_W){1'b0}}, r_out_min, {FRAC_W{1'b0}}});
    assign w_t_hi = (w_mac_res > w_hi) ? w_hi : w_mac_res;
    assign w_t    = (w_t_hi < w_lo) ? w_lo : w_t_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_min   <= 8'd0;
            r_out_max   <= 8'd100;
            r_sum       <= '0;
            r_count     <= '0;
            r_run_mode  <= FUNC_MEASURE;
            r_low_meas  <= '0;
            r_high_meas <= '0;
            r_low_ref   <= '0;
            r_high_ref  <= '0;
            r_slope     <= SLOPE_W'(1 << FRAC_W);
            r_icpt      <= '0;
            r_out_valid <= 1'b0;
            r_div.start <= 1'b0;
            r_mac.start <= 1'b0;
        end else begin
            r_div.start <= w_div_start;
            r_mac.start <= w_mac_start;

            if (w_cfg_wr) begin
                if (paddr[2] == REG_OUT_MIN) begin
                    r_out_min <= pwdata[7:0];
                end else begin
                    r_out_max <= pwdata[7:0];
                end
            end

            if (r_state == S_FINISH && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_target <= i_target;
                        r_func   <= t_func'(i_func);
                        if (t_func'(i_func) == FUNC_CAL) begin
                            r_sum   <= '0;
                            r_count <= '0;
                            if (w_dm == '0) begin
                                r_res_kind  <= KIND_FAIL;
                                r_res_value <= '0;
                                r_state     <= S_FINISH;
                            end else begin
                                r_neg          <= w_dm[ADC_BITS] ^ w_dt[TGT_W];
                                r_div.dividend <= DIV_W'({w_dt_mag, {FRAC_W{1'b0}}});
                                r_div.divisor  <= DVSR_W'(w_dm_mag);
                                r_state        <= S_CAL_DIV;
                            end
                        end else begin
                            r_run_mode <= t_func'(i_func);
                            if (n_count == CNT_W'(NUM_SAMPLES)) begin
                                r_sum       <= '0;
                                r_count     <= '0;
                                r_close_sum <= n_sum;
                                r_state     <= S_AVG;
                            end else begin
                                r_sum   <= n_sum;
                                r_count <= n_count;
                            end
                        end
                    end
                end
                S_AVG: begin
                    unique case (r_func)
                        FUNC_LOW: begin
                            r_low_meas  <= w_avg;
                            r_low_ref   <= r_target;
                            r_res_kind  <= KIND_LOW;
                            r_res_value <= '0;
                            r_state     <= S_FINISH;
                        end
                        FUNC_HIGH: begin
                            r_high_meas <= w_avg;
                            r_high_ref  <= r_target;
                            r_res_kind  <= KIND_HIGH;
                            r_res_value <= '0;
                            r_state     <= S_FINISH;
                        end
                        default: begin
                            // t = avg * slope + intercept * 2^8
                            r_mac.a <= MAC_A_W'(r_slope);
                            r_mac.b <= w_avg;
                            r_mac.c <= MAC_W'($signed({r_icpt, {ICPT_FRAC_W{1'b0}}}));
                            r_state <= S_MEAS;
                        end
                    endcase
                end
                S_MEAS: begin
                    if (w_mac_done) begin
                        r_res_kind  <= KIND_VALUE;
                        r_res_value <= w_t[FRAC_W+7:FRAC_W];
                        r_state     <= S_FINISH;
                    end
                end
                S_CAL_DIV: begin
                    if (w_div_done) begin
                        // offset = low_ref * 2^16 - gain * low_meas
                        r_gain  <= w_gain;
                        r_mac.a <= -MAC_A_W'(w_gain);
                        r_mac.b <= r_low_meas;
                        r_mac.c <= MAC_W'({r_low_ref, {FRAC_W{1'b0}}});
                        r_state <= S_CAL_MAC;
                    end
                end
                S_CAL_MAC: begin
                    if (w_mac_done) begin
                        // arithmetic shift gives the floor of the division by 2^8
                        r_slope     <= r_gain;
                        r_icpt      <= w_mac_res[ICPT_W+ICPT_FRAC_W-1:ICPT_FRAC_W];
                        r_res_kind  <= KIND_CAL;
                        r_res_value <= '0;
                        r_state     <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_free) begin
                        r_out_kind  <= r_res_kind;
                        r_out_value <= r_res_value;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_kind  = r_out_kind;
    assign o_value = r_out_value;

    a_count_below_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count < CNT_W'(NUM_SAMPLES))
        else $error("run count reached the run length without closing the run");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_AVG || r_state == S_CAL_DIV))
        else $error("division finished outside a wait state");

    a_value_only_measure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_kind != KIND_VALUE) |-> (r_out_value == 8'd0))
        else $error("non-measure result carries a nonzero value");

endmodule

// ===== bench/tb_averaged_two_point_sensor_calibrator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_averaged_two_point_sensor_calibrator_unit
// pushes measure runs, point captures and calibrate items through the
// calibrator with bursty input and a stalling receiver, and checks each
// result against an in-bench model of averaging, gain/offset and clamping
// ----------------------------------------------------------------------------
module tb_averaged_two_point_sensor_calibrator_unit;
    import atpsc_pkg::*;

    localparam int REG_OUT_MIN   = 0;
    localparam int REG_OUT_MAX   = 1;
    localparam int SAMPLE_MAX    = (1 << ADC_BITS) - 1;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 230;
    localparam int SETTLE_CYCLES = 48;
    localparam int LIMIT_CYCLES  = 600000;
    localparam int MAX_PRINTS    = 40;

    typedef struct packed {
        t_func               func;
        logic [ADC_BITS-1:0] sample;
        logic [TGT_W-1:0]    target;
    } t_item;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] value;
    } t_reading;

    typedef struct {
        int                  reps;
        t_func               func;
        logic [ADC_BITS-1:0] sample;
        logic [TGT_W-1:0]    target;
        bit                  typed;
        t_kind               kind;
        logic [7:0]          value;
    } t_stim_row;

    typedef enum {SCN_MEASURE, SCN_LOW, SCN_HIGH, SCN_PAIR, SCN_CAL, SCN_BROKEN, SCN_NOISE}
        t_scenario;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_pat;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [2:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_func;
    logic [ADC_BITS-1:0] i_sample;
    logic [TGT_W-1:0]    i_target;
    logic                o_valid;
    logic                i_stall;
    logic [2:0]          o_kind;
    logic [7:0]          o_value;

    // calibration model state
    logic [7:0]                cfg_min   = 8'd0;
    logic [7:0]                cfg_max   = 8'd100;
    int                        run_sum   = 0;
    int                        run_cnt   = 0;
    t_func                     run_mode  = FUNC_MEASURE;
    logic [ADC_BITS-1:0]       low_meas  = '0;
    logic [ADC_BITS-1:0]       high_meas = '0;
    logic [TGT_W-1:0]          low_ref   = '0;
    logic [TGT_W-1:0]          high_ref  = '0;
    logic signed [SLOPE_W-1:0] gain      = SLOPE_W'(1 <<< FRAC_W);
    logic signed [ICPT_W-1:0]  offset    = '0;

    t_reading   pending_readings[$];
    int         mismatches = 0;
    int         items_sent = 0;
    int         burst_left = 0;
    longint     cycle_cnt  = 0;
    t_stall_pat stall_pat  = STALL_NONE;
    int         stall_left = 0;
    int         stall_tick = 0;

    t_stim_row dir_rows [6] = '{
        '{1,  FUNC_CAL,     10'd5,    8'd7,   1'b1, KIND_FAIL,  8'd0},
        '{10, FUNC_MEASURE, 10'd1023, 8'd255, 1'b1, KIND_VALUE, 8'd100},
        '{3,  FUNC_LOW,     10'd0,    8'd255, 1'b0, KIND_VALUE, 8'd0},
        '{2,  FUNC_HIGH,    10'd1023, 8'd0,   1'b0, KIND_VALUE, 8'd0},
        '{1,  FUNC_CAL,     10'd1023, 8'd0,   1'b1, KIND_FAIL,  8'd0},
        '{10, FUNC_MEASURE, 10'd0,    8'd0,   1'b1, KIND_VALUE, 8'd0}
    };

    logic [7:0] lim_lo_tab [6] = '{8'd0,   8'd0,   8'd255, 8'd0, 8'd255, 8'd200};
    logic [7:0] lim_hi_tab [6] = '{8'd100, 8'd255, 8'd0,   8'd0, 8'd255, 8'd30};

    averaged_two_point_sensor_calibrator_unit u_top (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic longint saturate(input longint v, input int w);
        longint top;
        top = (longint'(1) <<< (w - 1)) - 1;
        if (v > top) return top;
        if (v < -top - 1) return -top - 1;
        return v;
    endfunction

    // advances the model by one item, returns 1 when the item yields a result
    function automatic bit calibrator_step(input t_item it, output t_reading res);
        longint dm, dt, g, o, t, lim_hi, lim_lo;
        int     avg;
        res.kind  = KIND_VALUE;
        res.value = '0;
        if (it.func == FUNC_CAL) begin
            // partial run is dropped, its mode stays
            run_sum = 0;
            run_cnt = 0;
            dm = longint'(high_meas) - longint'(low_meas);
            dt = longint'(high_ref) - longint'(low_ref);
            if (dm == 0) begin
                res.kind = KIND_FAIL;
            end else begin
                g = saturate((dt * 65536) / dm, SLOPE_W);
                o = longint'(low_ref) * 65536 - g * longint'(low_meas);
                // arithmetic shift rounds toward minus infinity
                offset = ICPT_W'(saturate(o >>> ICPT_FRAC_W, ICPT_W));
                gain   = SLOPE_W'(g);
                res.kind = KIND_CAL;
            end
            return 1'b1;
        end
        if (it.func != run_mode) begin
            run_sum  = 0;
            run_cnt  = 0;
            run_mode = it.func;
        end
        run_sum += int'(it.sample);
        run_cnt++;
        if (run_cnt < NUM_SAMPLES) return 1'b0;
        avg     = run_sum / NUM_SAMPLES;
        run_sum = 0;
        run_cnt = 0;
        case (it.func)
            FUNC_MEASURE: begin
                t = longint'(avg) * longint'(gain) + longint'(offset) * 256;
                lim_hi = longint'(cfg_max) * 65536;
                lim_lo = longint'(cfg_min) * 65536;
                // lower clamp last, so inverted limits give out_min
                if (t > lim_hi) t = lim_hi;
                if (t < lim_lo) t = lim_lo;
                res.value = 8'(t >>> FRAC_W);
            end
            FUNC_LOW: begin
                low_meas = ADC_BITS'(avg);
                low_ref  = it.target;
                res.kind = KIND_LOW;
            end
            default: begin
                high_meas = ADC_BITS'(avg);
                high_ref  = it.target;
                res.kind  = KIND_HIGH;
            end
        endcase
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("mismatch on %s: got %0d, expected %0d (cycle %0d)",
                     what, got, want, cycle_cnt);
    endtask

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input t_item it, input bit typed, input t_reading typed_res);
        t_reading res;
        int       gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        burst_left--;
        i_valid  <= 1'b1;
        i_func   <= it.func;
        i_sample <= it.sample;
        i_target <= it.target;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        if (calibrator_step(it, res)) pending_readings.push_back(typed ? typed_res : res);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) @(negedge i_clk);
        // an item that closed no run may still be in flight
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        burst_left = 0;
    endtask

    task automatic write_reg(input int idx, input logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(idx * 4);
        pwdata  <= {24'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (pready !== 1'b1) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_OUT_MIN) cfg_min = val;
        else if (idx == REG_OUT_MAX) cfg_max = val;
    endtask

    task automatic play_run(input t_func f, input int n, input int base, input int spread);
        t_item it;
        int    k, s;
        for (k = 0; k < n; k++) begin
            if (spread > 64) s = $urandom_range(0, SAMPLE_MAX);
            else s = base + int'($urandom_range(0, 2 * spread)) - spread;
            if (s < 0) s = 0;
            if (s > SAMPLE_MAX) s = SAMPLE_MAX;
            it.func   = f;
            it.sample = ADC_BITS'(s);
            it.target = TGT_W'($urandom_range(0, 255));
            send_item(it, 1'b0, '0);
        end
    endtask

    task automatic play_scenario();
        t_scenario scn;
        t_item     it;
        int        pick, base, spread, delta, k;
        pick = $urandom_range(0, 99);
        if (pick < 30) scn = SCN_MEASURE;
        else if (pick < 40) scn = SCN_LOW;
        else if (pick < 50) scn = SCN_HIGH;
        else if (pick < 75) scn = SCN_PAIR;
        else if (pick < 82) scn = SCN_CAL;
        else if (pick < 92) scn = SCN_BROKEN;
        else scn = SCN_NOISE;
        case ($urandom_range(0, 5))
            0: base = 0;
            1: base = SAMPLE_MAX;
            default: base = $urandom_range(0, SAMPLE_MAX);
        endcase
        case ($urandom_range(0, 4))
            0, 1: spread = 0;
            2, 3: spread = $urandom_range(1, 8);
            default: spread = SAMPLE_MAX;
        endcase
        case (scn)
            SCN_MEASURE: play_run(FUNC_MEASURE, NUM_SAMPLES, base, spread);
            SCN_LOW: play_run(FUNC_LOW, NUM_SAMPLES, base, spread);
            SCN_HIGH: play_run(FUNC_HIGH, NUM_SAMPLES, base, spread);
            SCN_PAIR: begin
                // close points give steep gains, a zero delta with no spread equal points
                case ($urandom_range(0, 3))
                    0: delta = 0;
                    1: delta = int'($urandom_range(0, 6)) - 3;
                    default: delta = int'($urandom_range(0, SAMPLE_MAX)) - base;
                endcase
                play_run(FUNC_LOW, NUM_SAMPLES, base, spread);
                play_run(FUNC_HIGH, NUM_SAMPLES, base + delta, spread);
                it.func   = FUNC_CAL;
                it.sample = ADC_BITS'($urandom_range(0, SAMPLE_MAX));
                it.target = TGT_W'($urandom_range(0, 255));
                send_item(it, 1'b0, '0);
            end
            SCN_CAL: begin
                it.func   = FUNC_CAL;
                it.sample = ADC_BITS'($urandom_range(0, SAMPLE_MAX));
                it.target = TGT_W'($urandom_range(0, 255));
                send_item(it, 1'b0, '0);
            end
            SCN_BROKEN: play_run(t_func'($urandom_range(0, 2)),
                                 $urandom_range(1, NUM_SAMPLES - 1), base, spread);
            default: begin
                for (k = $urandom_range(1, 4); k > 0; k--) begin
                    it.func   = t_func'($urandom_range(0, 3));
                    it.sample = ADC_BITS'($urandom_range(0, SAMPLE_MAX));
                    it.target = TGT_W'($urandom_range(0, 255));
                    send_item(it, 1'b0, '0);
                end
            end
        endcase
    endtask

    // receiver back-pressure, switching between patterns
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_pat  = t_stall_pat'($urandom_range(0, 3));
            stall_left = $urandom_range(32, 400);
        end
        stall_left--;
        stall_tick++;
        case (stall_pat)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= ((stall_tick % 7) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_stall === 1'b0) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("result with no item pending, kind", o_kind, -1);
            end else begin
                want = pending_readings.pop_front();
                if (o_kind !== want.kind) report_mismatch("kind", o_kind, want.kind);
                if (o_value !== want.value) report_mismatch("value", o_value, want.value);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        t_item      it;
        t_reading   typed_res;
        logic [7:0] lo, hi;
        int         r, k, ph, phase_start;
        i_rst_n  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        i_valid  = 1'b0;
        i_func   = '0;
        i_sample = '0;
        i_target = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (r = 0; r < $size(dir_rows); r++) begin
            for (k = 0; k < dir_rows[r].reps; k++) begin
                it.func         = dir_rows[r].func;
                it.sample       = dir_rows[r].sample;
                it.target       = dir_rows[r].target;
                typed_res.kind  = dir_rows[r].kind;
                typed_res.value = dir_rows[r].value;
                send_item(it, dir_rows[r].typed && k == dir_rows[r].reps - 1, typed_res);
            end
        end

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            // sender holds off until every result is back, then retunes the limits
            wait_idle();
            if (ph < $size(lim_lo_tab)) begin
                lo = lim_lo_tab[ph];
                hi = lim_hi_tab[ph];
            end else begin
                lo = 8'($urandom_range(0, 255));
                hi = 8'($urandom_range(0, 255));
            end
            write_reg(REG_OUT_MIN, lo);
            write_reg(REG_OUT_MAX, hi);
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS) play_scenario();
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/atpsc_pkg.sv
design/atpsc_div.sv
design/atpsc_mac.sv
design/averaged_two_point_sensor_calibrator_unit.sv
bench/tb_averaged_two_point_sensor_calibrator_unit.sv
